// ----- src/pli_pkg.sv -----
// Shared constants and types for the piecewise linear interpolator.
package pli_pkg;

  // Points per curve; the store holds the left curve and then the right one.
  localparam int POINTS    = 32;
  localparam int PTR_W     = $clog2(POINTS);
  localparam int ADDR_W    = PTR_W + 1;
  localparam int DEPTH     = 2 * POINTS;
  localparam int ENTRY_W   = 64;

  // Fixed field widths.
  localparam int CNT_W     = 6;
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 32;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  // Configuration register indexes.
  localparam logic REG_LEFT_COUNT  = 1'b0;
  localparam logic REG_RIGHT_COUNT = 1'b1;

  // Input action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

// ----- src/pli_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/piecewise_linear_interpolator.sv -----
// Top level of the piecewise linear interpolator over two breakpoint curves.
//
// Usage: the slave stream takes one beat per item. s_tuser[0] is the action
// (load a point or query) and s_tuser[1] the curve side. A load writes one
// (s, l) point into the curve store and gives no result.
// A query gives exactly one master beat: m_tuser[0] is found, m_tdata the
// interpolated lateral offset in Q16.16 (zero when not found).
// Point counts are set on the write port (cfg_we, cfg_index, cfg_data); the
// user must write them only while the block is idle; the block does not enforce it.
// A query on invalid curves answers not found; otherwise it clamps to the first
// point, clamps to the last point, or interpolates: a linear scan of the curve
// store reads one entry a cycle on its single read port, then a multiply state
// and a 32-step restoring divide, then the final add and hand-off.
// One query is worked on at a time; s_tready is high while the sequencer is
// idle, also while a finished result waits in the output register.
// Reset (rst, synchronous) clears the counts, the sequencer and the output
// valid; the curve store is not cleared and must be loaded before use.
// While m_tready is low the result holds and a following query waits at
// its end until the output register is free.
module piecewise_linear_interpolator
  import pli_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CNT_W-1:0]   cfg_data,
  // Input stream.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [71:0]        s_tdata,  // point_index[4:0], position_s[36:5], point_l[68:37]
  input  logic [1:0]         s_tuser,  // action[0], curve_side[1]
  // Result stream.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VAL_W-1:0]   m_tdata,  // lateral_l[31:0]
  output logic               m_tuser   // found[0]
);

  // Input field split.
  logic                      in_action;
  logic                      in_side;
  logic [IDX_W-1:0]          in_index;
  logic signed [VAL_W-1:0]   in_s;
  logic signed [VAL_W-1:0]   in_l;

  assign in_action = s_tuser[0];
  assign in_side   = s_tuser[1];
  assign in_index  = s_tdata[4:0];
  assign in_s      = s_tdata[36:5];
  assign in_l      = s_tdata[68:37];

  // Registers.
  state_t                    state, state_next;
  logic [CNT_W-1:0]          left_count, right_count;
  logic                      side;
  logic signed [VAL_W-1:0]   q;
  logic [CNT_W-1:0]          n;
  logic [PTR_W-1:0]          idx;
  logic signed [VAL_W-1:0]   prev_s, prev_l;
  logic [VAL_W-1:0]          dq, ds, mag;
  logic                      neg;
  logic [VAL_W-1:0]          rem, low;
  logic [DIV_CNT_W-1:0]      cnt;
  logic                      res_found;
  logic signed [VAL_W-1:0]   res_l;
  logic                      out_valid;
  logic                      out_found;
  logic [VAL_W-1:0]          out_l;

  // Memory ports.
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;
  logic signed [VAL_W-1:0]   rd_s, rd_l;

  assign rd_s = ram_rdata[63:32];
  assign rd_l = ram_rdata[31:0];

  pli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_curve_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Accept conditions and query checks.
  logic                      accept, load_ok, query_start, curves_bad;
  logic [CNT_W-1:0]          in_n, nm1, left_eff, right_eff;
  logic                      scan_more, out_free;

  assign accept     = s_tvalid && s_tready;
  assign load_ok    = 32'(in_index) < 32'(POINTS);
  assign left_eff   = (32'(left_count) > 32'(POINTS)) ? CNT_W'(POINTS) : left_count;
  assign right_eff  = (32'(right_count) > 32'(POINTS)) ? CNT_W'(POINTS) : right_count;
  assign in_n       = in_side ? right_eff : left_eff;
  assign curves_bad = (left_count < CNT_W'(2)) || (right_count == '0);
  assign query_start = accept && (in_action == ACT_QUERY);
  assign nm1        = n - CNT_W'(1);
  assign scan_more  = (CNT_W'(idx) < nm1) && (rd_s < q);
  assign out_free   = !out_valid || m_tready;

  // Segment differences at the end of the scan.
  logic signed [VAL_W:0]     dq_w, ds_w, dl_w, mag_w;

  assign dq_w  = {q[VAL_W-1], q} - {prev_s[VAL_W-1], prev_s};
  assign ds_w  = {rd_s[VAL_W-1], rd_s} - {prev_s[VAL_W-1], prev_s};
  assign dl_w  = {rd_l[VAL_W-1], rd_l} - {prev_l[VAL_W-1], prev_l};
  assign mag_w = dl_w[VAL_W] ? -dl_w : dl_w;

  // Restoring divide step.
  logic [VAL_W:0]            trial, trial_sub;
  logic                      trial_ge;
  logic [2*VAL_W-1:0]        product;

  assign trial     = {rem, low[VAL_W-1]};
  assign trial_ge  = trial >= {1'b0, ds};
  assign trial_sub = trial - {1'b0, ds};
  assign product   = dq * mag;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_start) begin
          state_next = curves_bad ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_next = (q <= rd_s) ? ST_DONE : ST_LAST;
      end
      ST_LAST: begin
        state_next = (q >= rd_s) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == DIV_CNT_W'(VAL_W - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_we    = accept && (in_action == ACT_LOAD) && load_ok;
    ram_waddr = {in_side, PTR_W'(in_index)};
    ram_wdata = {in_s, in_l};
    ram_raddr = '0;
    case (state)
      ST_IDLE: begin
        ram_raddr = {in_side, PTR_W'(0)};
      end
      ST_FIRST: begin
        ram_raddr = {side, nm1[PTR_W-1:0]};
      end
      ST_LAST: begin
        ram_raddr = {side, PTR_W'(1)};
      end
      ST_SCAN: begin
        ram_raddr = {side, idx + PTR_W'(1)};
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      left_count  <= '0;
      right_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT_COUNT:  left_count  <= cfg_data;
          REG_RIGHT_COUNT: right_count <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        side      <= in_side;
        q         <= in_s;
        n         <= in_n;
        res_found <= 1'b0;
        res_l     <= '0;
      end
      ST_FIRST: begin
        prev_s <= rd_s;
        prev_l <= rd_l;
        if (q <= rd_s) begin
          res_found <= 1'b1;
          res_l     <= rd_l;
        end
      end
      ST_LAST: begin
        idx <= PTR_W'(1);
        if (q >= rd_s) begin
          res_found <= 1'b1;
          res_l     <= rd_l;
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          prev_s <= rd_s;
          prev_l <= rd_l;
          idx    <= idx + PTR_W'(1);
        end else begin
          dq  <= dq_w[VAL_W-1:0];
          ds  <= ds_w[VAL_W-1:0];
          mag <= mag_w[VAL_W-1:0];
          neg <= dl_w[VAL_W];
        end
      end
      ST_MUL: begin
        // The quotient fits 32 bits, so the upper half starts below ds.
        rem <= product[2*VAL_W-1:VAL_W];
        low <= product[VAL_W-1:0];
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= trial_ge ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
        low <= {low[VAL_W-2:0], trial_ge};
        cnt <= cnt + DIV_CNT_W'(1);
      end
      ST_ADD: begin
        res_found <= 1'b1;
        res_l     <= neg ? prev_l - $signed(low) : prev_l + $signed(low);
      end
      default: ;
    endcase
    if (state == ST_DONE && out_free) begin
      out_found <= res_found;
      out_l     <= res_l;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_l;
  assign m_tuser  = out_found;

`ifndef SYNTHESIS
  // The scan never reads past the last point of the curve.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CNT_W'(idx) <= nm1)
    else $error("scan index beyond curve end");

  // The partial remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < ds)
    else $error("divide remainder not below divisor");

  // The quotient never exceeds the offset difference.
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD |-> low <= mag)
    else $error("quotient exceeds offset difference");

  // A query on invalid curves answers zero.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !res_found |-> res_l == '0)
    else $error("not-found result is nonzero");

  // A finished result reaches the output register when it is free.
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> m_tvalid && state == ST_IDLE)
    else $error("result not handed to output");
`endif

endmodule
